>>> rtl/scrolling_led_panel_scan_out_macros.svh
// Assertion helpers used by the checker file.
`ifndef SCROLLING_LED_PANEL_SCAN_OUT_MACROS_SVH
`define SCROLLING_LED_PANEL_SCAN_OUT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define SLPSO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked property that also holds through reset.
`define SLPSO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

>>> rtl/slpso_pkg.sv
package slpso_pkg;

    // Default message length in glyphs
    localparam int MSG_CHARS_DEF = 32;

    // Glyph geometry: 16 rows of two bytes
    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_BYTES = GLYPH_ROWS * 2;

    // Codes of the char_index field (5 bits)
    localparam int CHAR_CODES = 32;

    // Beats per render
    localparam int RENDER_BEATS = 16;

    // Request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [9:0] store_address;
        logic [7:0] write_byte;
        logic [4:0] char_index;
        logic [3:0] pixel_offset;
        logic [1:0] scan_group;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [1:0] row_group;
        logic       last;
    } t_out_beat;

endpackage

>>> rtl/slpso_ram.sv
module slpso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/scrolling_led_panel_scan_out.sv
// Scan-out engine for a quarter-scan single-colour LED panel with a scrolling
// message. The block holds MSG_CHARS glyphs of 16x16 pixels (32 bytes each) in
// a glyph store that is undefined until written; there is no clearing pass, so
// every glyph shown must be written first. A write beat stores one glyph byte
// at char*32 + row*2 + half and yields no output. A render beat selects a
// 32-pixel window starting pixel_offset pixels into glyph char_index
// (wrapping past the last glyph) and yields 16 output beats for one scan
// group g: for window bytes 0..3, rows g+12, g+8, g+4, g+0, each byte
// inverted for active-low data pins and meant to be shifted MSB first. The
// sixteenth beat has last set and carries g in row_group (zero before that).
// A render yields one output beat per cycle while the output is not stalled:
// each beat needs two adjacent stream bytes, fetched through the two read
// ports of the glyph store, so the store's read bandwidth sets that rate. The
// first beat passes the fetch stage and the output register. The next item is
// taken in the cycle that issues the final fetch, and while output beats wait
// downstream the input side stays open as long as no render is in progress.
module scrolling_led_panel_scan_out
    import slpso_pkg::*;
#(
    parameter int MSG_CHARS = MSG_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    localparam int GW          = $clog2(MSG_CHARS);
    localparam int STORE_DEPTH = MSG_CHARS * GLYPH_BYTES;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam logic [3:0] LAST_BEAT = 4'(RENDER_BEATS - 1);

    // char code -> glyph number modulo the message length, built at elaboration
    function automatic logic [CHAR_CODES*GW-1:0] build_mod_tab();
        logic [CHAR_CODES*GW-1:0] tab;
        tab = '0;
        for (int i = 0; i < CHAR_CODES; i++) begin
            tab[i*GW +: GW] = GW'(i % MSG_CHARS);
        end
        return tab;
    endfunction

    localparam logic [CHAR_CODES*GW-1:0] CHAR_MOD_TAB = build_mod_tab();

    // --- render sequencer ---
    logic          r_busy;
    logic [3:0]    r_cnt;
    logic [GW-1:0] r_first;
    logic [3:0]    r_off;
    logic [1:0]    r_grp;

    // --- fetch stage (alongside the registered RAM read) ---
    logic          r_s1_vld;
    logic [2:0]    r_s1_sh;
    logic          r_s1_last;
    logic [1:0]    r_s1_grp;

    // --- output register ---
    logic          r_out_vld;
    t_out_beat     r_out;

    logic          en;
    logic          issue;
    logic          in_acc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [2:0]    j0;
    logic [2:0]    j1;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [7:0]    rd_a;
    logic [7:0]    rd_b;
    logic [15:0]   pair;
    t_out_beat     n_out;

    // Stream byte j of the current row: glyph first + j/2, half j[0]
    function automatic logic [AW-1:0] stream_addr(
        input logic [GW-1:0] first,
        input logic [2:0]    j,
        input logic [3:0]    row
    );
        logic [GW:0] sum;
        logic [GW:0] glyph;
        sum   = {1'b0, first} + (GW+1)'(j[2:1]);
        glyph = (sum >= (GW+1)'(MSG_CHARS)) ? sum - (GW+1)'(MSG_CHARS) : sum;
        return {glyph[GW-1:0], row, j[0]};
    endfunction

    // Whole pipeline moves together whenever the output register can take a beat
    assign en     = !r_out_vld || !i_out_stall;
    assign issue  = r_busy && en;

    // Open for the next item once the final fetch of a render goes out
    assign o_in_stall = r_busy && !(r_cnt == LAST_BEAT && en);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_en      = in_acc && (i_in_data.req_type == REQ_WRITE);

    // Wrap the byte address into the store: glyph part modulo the message length
    assign wr_addr = {CHAR_MOD_TAB[i_in_data.store_address[9:5]*GW +: GW],
                      i_in_data.store_address[4:0]};

    // Window byte wb starts at stream byte wb + off[3], bit off[2:0]
    assign j0 = {1'b0, r_cnt[3:2]} + {2'b00, r_off[3]};
    assign j1 = j0 + 3'd1;

    // Row for beat q is grp + (3 - q % 4) * 4
    assign rd_addr_a = stream_addr(r_first, j0, {~r_cnt[1:0], r_grp});
    assign rd_addr_b = stream_addr(r_first, j1, {~r_cnt[1:0], r_grp});

    slpso_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_glyph_store (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (i_in_data.write_byte),
        .i_re      (issue),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Align the window byte and invert for the active-low pins
    assign pair = {rd_a, rd_b} << r_s1_sh;

    always_comb begin
        n_out.pixel_byte = ~pair[15:8];
        n_out.row_group  = r_s1_last ? r_s1_grp : 2'd0;
        n_out.last       = r_s1_last;
    end

    // Sequencer: hold the render's parameters and advance one beat per issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (in_acc && i_in_data.req_type == REQ_RENDER) begin
            // a new render takes over in the cycle the previous one retires
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (issue) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == LAST_BEAT) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.req_type == REQ_RENDER) begin
            r_first <= CHAR_MOD_TAB[i_in_data.char_index*GW +: GW];
            r_off   <= i_in_data.pixel_offset;
            r_grp   <= i_in_data.scan_group;
        end
    end

    // Fetch stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= issue;
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sh   <= r_off[2:0];
            r_s1_last <= (r_cnt == LAST_BEAT);
            r_s1_grp  <= r_grp;
            r_out     <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> rtl/slpso_checker.sv
`include "scrolling_led_panel_scan_out_macros.svh"

module slpso_checker
    import slpso_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_beat  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_beat o_out_data,
    input logic      i_out_stall
);

    // a stalled output beat holds
    `SLPSO_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "output beat changed under stall")

    // row group is only shown on the closing beat
    `SLPSO_ASSERT(a_grp_last, o_out_valid && !o_out_data.last |-> o_out_data.row_group == 2'd0, "row group set before the closing beat")

    // a taken render keeps the input closed in the next cycle
    `SLPSO_ASSERT(a_render_busy, i_in_valid && !o_in_stall && i_in_data.req_type == REQ_RENDER |=> o_in_stall, "input open straight after a render")

    // two closing beats never follow each other
    `SLPSO_ASSERT_ALWAYS(a_last_gap, i_rst_n && o_out_valid && o_out_data.last && !i_out_stall |=> !(o_out_valid && o_out_data.last), "closing beats back to back")

endmodule

bind scrolling_led_panel_scan_out slpso_checker u_slpso_checker (.*);
